>>> rtl/mie_pkg.sv
// package for the integer execute block: opcodes, funct codes, states, constants
// no dependencies
package mie_pkg;
    localparam int REG_COUNT_DEF = 32;
    localparam int XLEN = 64;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    localparam logic [63:0] JMP_MASK = 64'hFFFF_FFFF_F000_0000;
    localparam logic [4:0]  LINK_REG = 5'd31;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_OUT
    } t_state;
endpackage

>>> rtl/mie_if.sv
// valid/ready channel interfaces for instruction items and result items
// no dependencies
interface mie_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface mie_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [63:0] written_value;
    logic [63:0] hi_value;
    logic [63:0] lo_value;
    logic        unknown_op;
    modport source (output valid, output next_pc, output reg_written, output written_index,
                    output written_value, output hi_value, output lo_value,
                    output unknown_op, input ready);
    modport sink   (input valid, input next_pc, input reg_written, input written_index,
                    input written_value, input hi_value, input lo_value,
                    input unknown_op, output ready);
endinterface

>>> rtl/mie_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module mie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mie_divider.sv
// radix-2 restoring divider for 64-bit unsigned operands, one bit per cycle
// depends on mie_pkg
module mie_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic [63:0] r_quot;
    logic [63:0] r_rem;
    logic [63:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_trial;
    logic [64:0] w_diff;

    assign w_trial = {r_rem, r_quot[mie_pkg::XLEN-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'(mie_pkg::XLEN);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
                r_quot <= {r_quot[62:0], 1'b1};
            end else begin
                r_rem <= w_trial[63:0];
                r_quot <= {r_quot[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 7'd1);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

>>> rtl/mips_integer_execute.sv
// top level of the integer execute block: sequencer, alu, branch unit and register file
// depends on mie_pkg, mie_if, mie_ram, mie_divider
// The block executes one 32-bit instruction per item against 32 general registers held in two
// copies of a synchronous ram (one per read port), a program counter and hi/lo. After reset a
// clearing pass zeroes the register file, one entry a cycle, while no item is accepted. An
// ordinary instruction then passes through register read, then execute, with the result
// registered on entry to the output state and written back from there. Multiply adds a state
// for its 32x32 product; divide passes through that state to start the bit-serial divider, then
// waits in the divide state and takes a sign-correction state, while a divide by zero adds only
// the first of these states. The next item is accepted in the cycle after the result is taken.
// Register zero is never written back and reads as zero.
module mips_integer_execute #(
    parameter int REG_COUNT = mie_pkg::REG_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mie_instr_if.sink      i_instr,
    mie_result_if.source   o_result
);
    localparam int AW = $clog2(REG_COUNT);

    mie_pkg::t_state r_state, n_state;

    logic [31:0] r_iw;
    logic [63:0] r_pc, r_hi, r_lo;
    logic [AW:0] r_clr;
    logic [63:0] w_a_raw, w_b_raw, w_a, w_b;

    // operand-derived registers captured in execute
    logic [63:0] r_a, r_b;
    logic        r_wr;
    logic [4:0]  r_widx;
    logic [63:0] r_wval, r_npc;
    logic        r_bad;
    logic        r_neg_q, r_neg_r;

    // output register
    logic        r_ovalid;
    logic [63:0] r_onpc, r_owval, r_ohi, r_olo;
    logic        r_owr, r_obad;
    logic [4:0]  r_owidx;

    // instruction fields
    logic [5:0] w_op, w_fn;
    logic [4:0] w_rs, w_rt, w_rd, w_sh;
    assign w_op = r_iw[31:26];
    assign w_rs = r_iw[25:21];
    assign w_rt = r_iw[20:16];
    assign w_rd = r_iw[15:11];
    assign w_sh = r_iw[10:6];
    assign w_fn = r_iw[5:0];

    // register file write port: clearing pass or write-back
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [63:0]   w_wdata;
    assign w_we    = (r_state == mie_pkg::ST_CLEAR) || (r_state == mie_pkg::ST_OUT && r_wr);
    assign w_waddr = (r_state == mie_pkg::ST_CLEAR) ? r_clr[AW-1:0] : r_widx[AW-1:0];
    assign w_wdata = (r_state == mie_pkg::ST_CLEAR) ? '0 : r_wval;

    // operands are read from the held instruction, so the data is valid in execute
    logic          w_acc;
    logic [AW-1:0] w_ra, w_rb;
    assign w_acc = i_instr.valid && i_instr.ready;
    assign w_ra  = r_iw[21 +: AW];
    assign w_rb  = r_iw[16 +: AW];

    mie_ram #(.WIDTH(mie_pkg::XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_ra), .o_rdata(w_a_raw));
    mie_ram #(.WIDTH(mie_pkg::XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_rb), .o_rdata(w_b_raw));

    // register zero always reads as zero; write-back precedes next accept so no forwarding needed
    assign w_a = (w_rs == 5'd0) ? '0 : w_a_raw;
    assign w_b = (w_rt == 5'd0) ? '0 : w_b_raw;

    // divider operates on magnitudes
    logic        w_div_start, w_div_done;
    logic [63:0] w_quot, w_rem, w_dvd, w_dvs;
    logic        w_signed_div;
    assign w_signed_div = (w_fn == mie_pkg::FN_DIV);
    assign w_dvd = (w_signed_div && r_a[63]) ? (64'd0 - r_a) : r_a;
    assign w_dvs = (w_signed_div && r_b[63]) ? (64'd0 - r_b) : r_b;
    assign w_div_start = (r_state == mie_pkg::ST_MUL) && (w_fn == mie_pkg::FN_DIV
                         || w_fn == mie_pkg::FN_DIVU) && (r_b != 64'd0);

    mie_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_done(w_div_done), .o_quot(w_quot), .o_rem(w_rem));

    // execute logic
    logic [63:0] w_seq, w_imm_s, w_imm_z, w_br, w_sum;
    logic        e_wr, e_bad, e_md;
    logic [4:0]  e_widx;
    logic [63:0] e_wval, e_npc;
    assign w_seq   = r_pc + 64'd4;
    assign w_imm_s = {{48{r_iw[15]}}, r_iw[15:0]};
    assign w_imm_z = {48'd0, r_iw[15:0]};
    assign w_br    = w_seq + {w_imm_s[61:0], 2'b00};
    assign w_sum   = w_a + ((w_op == mie_pkg::OP_SPECIAL) ? w_b : w_imm_s);

    always_comb begin
        e_wr   = 1'b0;
        e_bad  = 1'b0;
        e_md   = 1'b0;
        e_widx = w_rt;
        e_wval = '0;
        e_npc  = w_seq;
        unique case (w_op)
            mie_pkg::OP_SPECIAL: begin
                e_widx = w_rd;
                e_wr   = 1'b1;
                unique case (w_fn)
                    mie_pkg::FN_ADD, mie_pkg::FN_ADDU: e_wval = w_sum;
                    mie_pkg::FN_SUB, mie_pkg::FN_SUBU: e_wval = w_a - w_b;
                    mie_pkg::FN_AND:  e_wval = w_a & w_b;
                    mie_pkg::FN_OR:   e_wval = w_a | w_b;
                    mie_pkg::FN_XOR:  e_wval = w_a ^ w_b;
                    mie_pkg::FN_NOR:  e_wval = ~(w_a | w_b);
                    mie_pkg::FN_SLT:  e_wval = {63'd0, $signed(w_a) < $signed(w_b)};
                    mie_pkg::FN_SLTU: e_wval = {63'd0, w_a < w_b};
                    mie_pkg::FN_SLL:  e_wval = w_b << w_sh;
                    mie_pkg::FN_SRL:  e_wval = w_b >> w_sh;
                    mie_pkg::FN_SRA:  e_wval = 64'($signed(w_b) >>> w_sh);
                    mie_pkg::FN_JR: begin
                        e_wr  = 1'b0;
                        e_npc = w_a;
                    end
                    mie_pkg::FN_JALR: begin
                        e_wval = w_seq;
                        e_npc  = w_a;
                    end
                    mie_pkg::FN_MULT, mie_pkg::FN_MULTU,
                    mie_pkg::FN_DIV, mie_pkg::FN_DIVU: begin
                        e_wr = 1'b0;
                        e_md = 1'b1;
                    end
                    default: begin
                        e_wr  = 1'b0;
                        e_bad = 1'b1;
                    end
                endcase
            end
            mie_pkg::OP_J, mie_pkg::OP_JAL: begin
                e_npc  = (w_seq & mie_pkg::JMP_MASK) | {36'd0, r_iw[25:0], 2'b00};
                e_wr   = (w_op == mie_pkg::OP_JAL);
                e_widx = mie_pkg::LINK_REG;
                e_wval = w_seq;
            end
            mie_pkg::OP_BEQ:  if (w_a == w_b) e_npc = w_br;
            mie_pkg::OP_BNE:  if (w_a != w_b) e_npc = w_br;
            mie_pkg::OP_BLEZ: if (w_a == 64'd0 || w_a[63]) e_npc = w_br;
            mie_pkg::OP_BGTZ: if (!(w_a == 64'd0 || w_a[63])) e_npc = w_br;
            mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin
                e_wr = 1'b1; e_wval = w_sum;
            end
            mie_pkg::OP_ANDI: begin
                e_wr = 1'b1; e_wval = w_a & w_imm_z;
            end
            mie_pkg::OP_ORI: begin
                e_wr = 1'b1; e_wval = w_a | w_imm_z;
            end
            mie_pkg::OP_XORI: begin
                e_wr = 1'b1; e_wval = w_a ^ w_imm_z;
            end
            mie_pkg::OP_LUI: begin
                e_wr = 1'b1; e_wval = {{32{r_iw[15]}}, r_iw[15:0], 16'd0};
            end
            default: e_bad = 1'b1;
        endcase
        if (e_bad) begin
            e_npc = r_pc;
        end
        // writes to register zero are dropped and reported as no write
        if (!e_wr || e_widx == 5'd0) begin
            e_wr   = 1'b0;
            e_widx = '0;
            e_wval = '0;
        end
    end

    // 32x32 multiply on the operands registered in execute
    logic [63:0] w_ma, w_mb, w_mprod;
    logic [65:0] w_mfull;
    assign w_ma = (w_fn == mie_pkg::FN_MULT) ? {{32{r_a[31]}}, r_a[31:0]} : {32'd0, r_a[31:0]};
    assign w_mb = (w_fn == mie_pkg::FN_MULT) ? {{32{r_b[31]}}, r_b[31:0]} : {32'd0, r_b[31:0]};
    assign w_mfull = $signed({w_ma[32], w_ma[31:0]}) * $signed({w_mb[32], w_mb[31:0]});
    assign w_mprod = w_mfull[63:0];

    assign i_instr.ready = (r_state == mie_pkg::ST_IDLE)
                        || (r_state == mie_pkg::ST_OUT && !r_ovalid);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mie_pkg::ST_CLEAR:  if (r_clr == (AW+1)'(REG_COUNT - 1)) n_state = mie_pkg::ST_IDLE;
            mie_pkg::ST_IDLE:   if (w_acc) n_state = mie_pkg::ST_READ;
            mie_pkg::ST_READ:   n_state = mie_pkg::ST_EXEC;
            mie_pkg::ST_EXEC:   n_state = e_md ? mie_pkg::ST_MUL : mie_pkg::ST_OUT;
            mie_pkg::ST_MUL: begin
                if (w_div_start) n_state = mie_pkg::ST_DIV;
                else             n_state = mie_pkg::ST_OUT;
            end
            mie_pkg::ST_DIV:    if (w_div_done) n_state = mie_pkg::ST_DIVFIX;
            mie_pkg::ST_DIVFIX: n_state = mie_pkg::ST_OUT;
            mie_pkg::ST_OUT:    if (w_acc) n_state = mie_pkg::ST_READ;
            default:            n_state = mie_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mie_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mie_pkg::ST_CLEAR) begin
                r_clr <= r_clr + (AW+1)'(1);
            end
        end
    end

    // architectural pc, hi, lo and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_hi     <= '0;
            r_lo     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == mie_pkg::ST_EXEC) begin
                r_pc <= e_npc;
            end
            if (r_state == mie_pkg::ST_MUL && !e_md) begin
                // not reached: multiply/divide only enter this state
                r_hi <= r_hi;
            end else if (r_state == mie_pkg::ST_MUL
                         && (w_fn == mie_pkg::FN_MULT || w_fn == mie_pkg::FN_MULTU)) begin
                r_hi <= {{32{w_mprod[63]}}, w_mprod[63:32]};
                r_lo <= {{32{w_mprod[31]}}, w_mprod[31:0]};
            end
            if (r_state == mie_pkg::ST_DIVFIX) begin
                r_lo <= r_neg_q ? (64'd0 - w_quot) : w_quot;
                r_hi <= r_neg_r ? (64'd0 - w_rem) : w_rem;
            end
            if (n_state == mie_pkg::ST_OUT && r_state != mie_pkg::ST_OUT) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_iw <= i_instr.instr_word;
        end
        if (r_state == mie_pkg::ST_EXEC) begin
            r_a     <= w_a;
            r_b     <= w_b;
            r_wr    <= e_wr;
            r_widx  <= e_widx;
            r_wval  <= e_wval;
            r_npc   <= e_npc;
            r_bad   <= e_bad;
            r_neg_q <= w_signed_div && (w_a[63] != w_b[63]);
            r_neg_r <= w_signed_div && w_a[63];
        end
        if (r_state == mie_pkg::ST_OUT && !r_ovalid) begin
            r_wr <= 1'b0;
        end
    end

    // on the fast path the output is loaded straight from execute
    logic        r_wr_src, r_bad_src;
    logic [4:0]  r_widx_src;
    logic [63:0] r_npc_src, r_wval_src;
    always_comb begin
        if (r_state == mie_pkg::ST_EXEC) begin
            r_npc_src  = e_npc;
            r_wr_src   = e_wr;
            r_widx_src = e_widx;
            r_wval_src = e_wval;
            r_bad_src  = e_bad;
        end else begin
            r_npc_src  = r_npc;
            r_wr_src   = r_wr;
            r_widx_src = r_widx;
            r_wval_src = r_wval;
            r_bad_src  = r_bad;
        end
    end

    // output register loads on entry to the output state
    always_ff @(posedge i_clk) begin
        if (n_state == mie_pkg::ST_OUT && r_state != mie_pkg::ST_OUT) begin
            r_onpc  <= r_npc_src;
            r_owr   <= r_wr_src;
            r_owidx <= r_widx_src;
            r_owval <= r_wval_src;
            r_obad  <= r_bad_src;
        end
    end

    assign o_result.valid         = r_ovalid;
    assign o_result.next_pc       = r_onpc;
    assign o_result.reg_written   = r_owr;
    assign o_result.written_index = r_owidx;
    assign o_result.written_value = r_owval;
    assign o_result.hi_value      = r_hi;
    assign o_result.lo_value      = r_lo;
    assign o_result.unknown_op    = r_obad;
endmodule
